>>> design/ttcc_pkg.sv
`timescale 1ns / 1ps

package ttcc_pkg;

  // number of quotient bits, one restoring step per cell
  localparam int NCELL = 18;

  localparam logic [17:0] BRAKE_FULL = 18'h3FFFF;

  // register indexes
  localparam logic [1:0] REG_TTC_LIMIT = 2'd0;
  localparam logic [1:0] REG_MIN_CLOSE = 2'd1;
  localparam logic [1:0] REG_MAX_DECEL = 2'd2;

  // how the final ttc is formed
  localparam logic [1:0] TF_DIV   = 2'd0;
  localparam logic [1:0] TF_ZERO  = 2'd1;
  localparam logic [1:0] TF_LIMIT = 2'd2;

  typedef struct packed {
    logic signed [15:0] range_m;
    logic signed [15:0] ego_speed;
    logic signed [15:0] target_speed;
  } in_t;

  typedef struct packed {
    logic [15:0] ttc;
    logic [17:0] brake_dist;
    logic        closing;
  } out_t;

  // one slot of the divider chain: two restoring dividers side by side
  typedef struct packed {
    logic        valid;
    logic        closing;
    logic [1:0]  tforce;
    logic        bsat;
    logic [15:0] trem;
    logic [15:0] tdiv;
    logic [17:0] tdvd;
    logic [17:0] tq;
    logic [7:0]  brem;
    logic [7:0]  bdiv;
    logic [17:0] bdvd;
    logic [17:0] bq;
  } stage_t;

endpackage

>>> design/time_to_collision_calc.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// request   in         start & !busy         in_data  (range_m, ego_speed, target_speed)
// result    out        out_valid, 1 cycle    out_data (ttc, brake_dist, closing)
// config    in         cfg_we                cfg_idx, cfg_wdata
//
// One request per cycle while busy is low; each result passes through the input
// register, 18 restoring-divider cells (one quotient bit each for both ttc
// and braking distance) and the output register.
// Synchronous active-low reset clears valid flags and loads register defaults;
// busy is high while reset is held and for the first cycle after it. The
// receiver cannot stall: a result is shown for exactly one cycle.

module time_to_collision_calc
  import ttcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_data,
  output logic        out_valid,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] ttc_limit_r;
  logic [14:0] min_close_r;
  logic [7:0]  max_decel_r;
  logic        busy_r;
  logic        acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttc_limit_r <= 16'd2560;
      min_close_r <= 15'd128;
      max_decel_r <= 8'd96;
      busy_r      <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx)
          REG_TTC_LIMIT: ttc_limit_r <= cfg_wdata;
          REG_MIN_CLOSE: min_close_r <= cfg_wdata[14:0];
          REG_MAX_DECEL: max_decel_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  assign busy = busy_r || !rst_n;
  assign acc  = start && !busy;

  stage_t chain [NCELL+1];

  ttcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req       (in_data),
    .min_close (min_close_r),
    .decel     (max_decel_r),
    .s_o       (chain[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    ttcc_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .s_i   (chain[g]),
      .s_o   (chain[g+1])
    );
  end

  ttcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_i       (chain[NCELL]),
    .ttc_limit (ttc_limit_r),
    .res_valid (out_valid),
    .res       (out_data)
  );

  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, 20))
    else $error("result without matching request");

  a_ttc_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.ttc <= $past(ttc_limit_r))
    else $error("ttc above limit");

  a_not_closing_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.closing |-> out_data.ttc == $past(ttc_limit_r))
    else $error("non-closing sample did not report limit");

endmodule

>>> design/ttcc_front.sv
`timescale 1ns / 1ps

module ttcc_front
  import ttcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc,
  input  in_t         req,
  input  logic [14:0] min_close,
  input  logic [7:0]  decel,
  output stage_t      s_o
);

  logic               valid_r;
  logic               closing_r, closing_nxt;
  logic               ttc_on_r, ttc_on_nxt;
  logic signed [15:0] rng_r;
  logic signed [16:0] vrel_r, vrel_nxt;
  logic [31:0]        esq_r, esq_nxt;
  logic [7:0]         decel_r;
  logic [15:0]        ego_u, ego_abs;

  always_comb begin
    vrel_nxt    = 17'(signed'(req.ego_speed)) - 17'(signed'(req.target_speed));
    closing_nxt = !vrel_nxt[16] && (vrel_nxt != 17'sd0);
    ttc_on_nxt  = vrel_nxt > $signed({2'b00, min_close});
    ego_u       = req.ego_speed;
    ego_abs     = ego_u[15] ? (~ego_u + 16'd1) : ego_u;
    esq_nxt     = ego_abs * ego_abs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc;
    end
    closing_r <= closing_nxt;
    ttc_on_r  <= ttc_on_nxt;
    rng_r     <= req.range_m;
    vrel_r    <= vrel_nxt;
    esq_r     <= esq_nxt;
    decel_r   <= decel;
  end

  // dividend for ttc is range << 10; top 7 bits seed the remainder,
  // a seed at or above the divisor means the quotient overflows 18 bits
  // brake dividend is esq >> 7; its top 6 bits seed the remainder
  logic t_ovf, b_ovf;

  always_comb begin
    t_ovf = {9'd0, rng_r[14:8]} >= vrel_r[15:0];
    b_ovf = (decel_r == 8'd0) || ({2'b00, esq_r[30:25]} >= decel_r);

    s_o.valid   = valid_r;
    s_o.closing = closing_r;
    if (!ttc_on_r) begin
      s_o.tforce = TF_LIMIT;
    end else if (rng_r[15] || (rng_r == 16'sd0)) begin
      s_o.tforce = TF_ZERO;
    end else if (t_ovf) begin
      s_o.tforce = TF_LIMIT;
    end else begin
      s_o.tforce = TF_DIV;
    end
    s_o.trem = (s_o.tforce == TF_DIV) ? {9'd0, rng_r[14:8]} : 16'd0;
    s_o.tdiv = vrel_r[15:0];
    s_o.tdvd = {rng_r[7:0], 10'd0};
    s_o.tq   = 18'd0;
    s_o.bsat = b_ovf;
    s_o.brem = b_ovf ? 8'd0 : {2'b00, esq_r[30:25]};
    s_o.bdiv = decel_r;
    s_o.bdvd = esq_r[24:7];
    s_o.bq   = 18'd0;
  end

endmodule

>>> design/ttcc_cell.sv
`timescale 1ns / 1ps

module ttcc_cell
  import ttcc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  stage_t s_i,
  output stage_t s_o
);

  stage_t      s_r, s_nxt;
  logic [16:0] trem2;
  logic [8:0]  brem2;
  logic        tge, bge;

  always_comb begin
    trem2 = {s_i.trem, s_i.tdvd[17]};
    brem2 = {s_i.brem, s_i.bdvd[17]};
    tge   = trem2 >= {1'b0, s_i.tdiv};
    bge   = brem2 >= {1'b0, s_i.bdiv};

    s_nxt      = s_i;
    s_nxt.trem = tge ? 16'(trem2 - {1'b0, s_i.tdiv}) : trem2[15:0];
    s_nxt.tdvd = {s_i.tdvd[16:0], 1'b0};
    s_nxt.tq   = {s_i.tq[16:0], tge};
    s_nxt.brem = bge ? 8'(brem2 - {1'b0, s_i.bdiv}) : brem2[7:0];
    s_nxt.bdvd = {s_i.bdvd[16:0], 1'b0};
    s_nxt.bq   = {s_i.bq[16:0], bge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
    end else begin
      s_r <= s_nxt;
    end
  end

  assign s_o = s_r;

  a_trem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    s_r.valid && (s_r.tforce == TF_DIV) |-> s_r.trem < s_r.tdiv)
    else $error("ttc remainder not below divisor");

  a_brem_lt_div: assert property (@(posedge clk) disable iff (!rst_n)
    s_r.valid && !s_r.bsat |-> s_r.brem < s_r.bdiv)
    else $error("brake remainder not below divisor");

  a_tdiv_nz: assert property (@(posedge clk) disable iff (!rst_n)
    s_r.valid && (s_r.tforce == TF_DIV) |-> s_r.tdiv != 16'd0)
    else $error("ttc division by zero in chain");

endmodule

>>> design/ttcc_back.sv
`timescale 1ns / 1ps

module ttcc_back
  import ttcc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  stage_t      s_i,
  input  logic [15:0] ttc_limit,
  output logic        res_valid,
  output out_t        res
);

  logic valid_r;
  out_t res_r, res_nxt;

  always_comb begin
    case (s_i.tforce)
      TF_DIV:   res_nxt.ttc = (s_i.tq > {2'b00, ttc_limit}) ? ttc_limit : s_i.tq[15:0];
      TF_ZERO:  res_nxt.ttc = 16'd0;
      TF_LIMIT: res_nxt.ttc = ttc_limit;
      default:  res_nxt.ttc = ttc_limit;
    endcase
    res_nxt.brake_dist = s_i.bsat ? BRAKE_FULL : s_i.bq;
    res_nxt.closing    = s_i.closing;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s_i.valid;
    end
    res_r <= res_nxt;
  end

  assign res_valid = valid_r;
  assign res       = res_r;

endmodule
